/* rtl/vnm_pkg.sv */
package vnm_pkg;

	// command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ACCUM = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_UNDEF = 2'd3;

	// register indexes
	localparam logic [0:0] REG_PRESENCE = 1'd0;
	localparam logic [0:0] REG_MERGE    = 1'd1;

	localparam logic [15:0] PRESENCE_RESET = 16'd8192;
	localparam logic [15:0] MERGE_RESET    = 16'sd11469;

	localparam int FRAC_BITS = 14;

	// shared unit operations
	typedef enum logic [1:0] {
		OP_SQRT,
		OP_DIV
	} op_t;

	// request to the shared unit
	typedef struct packed {
		logic       start;
		op_t        op;
		logic [63:0] num;
		logic [31:0] den;
	} unit_req_t;

	// answer from the shared unit
	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} unit_rsp_t;

endpackage

/* rtl/vertex_normal_merge.sv */
// Per-node normal table with crease test. Commands: clear, accumulate, read.
// One word is taken at a time; tready is low while a word is being worked.
// Clear and undefined commands and an accumulate onto an absent normal do not
// use the shared unit. A read of a nonzero entry or an accumulate of a present
// normal runs one square root and three divisions on the shared
// one-bit-per-cycle unit; that unit sets the rate. After reset a clearing pass
// zeroes the table, one entry a cycle, during which tready stays low.
module vertex_normal_merge
	import vnm_pkg::*;
#(
	parameter int NODE_COUNT = 1024,
	parameter int COMP_BITS  = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tdata: node_index[9:0], elem_x, elem_y, elem_z (COMP_BITS each), zero pad
	input  logic [((10 + 3 * COMP_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser: command[1:0]
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tdata: out_node[9:0], unit_x, unit_y, unit_z (COMP_BITS each), zero pad
	output logic [((10 + 3 * COMP_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// tuser: zero_vector
	output logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);

	localparam int TW = ((10 + 3 * COMP_BITS + 7) / 8) * 8;
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int EW = 3 * COMP_BITS;
	localparam int PW = TW - 10 - EW;

	typedef logic signed [COMP_BITS-1:0] comp_t;

	localparam comp_t COMP_MAX = {1'b0, {(COMP_BITS - 1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(COMP_BITS - 1){1'b0}}};

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_RD, ST_SQ, ST_SQ2, ST_SQRT, ST_DIV, ST_DOT,
		ST_DOT2, ST_WR, ST_OUT
	} state_t;

	state_t      state_q;
	logic [AW:0] init_q;
	logic [15:0] pres_q;
	logic signed [15:0] merge_q;

	logic [EW-1:0] mem [NODE_COUNT];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [EW-1:0] wd;

	logic [1:0]  cmd_q;
	logic [9:0]  node_q;
	logic [AW-1:0] node_a;
	comp_t       e_q [3];
	comp_t       c_q [3];
	comp_t       u_q [3];
	logic [1:0]  k_q;
	logic [63:0] sq_q;
	logic [31:0] len_q;
	logic signed [63:0] dot_q;
	logic signed [63:0] prod_s1;
	logic        inr_q;
	logic        zero_q;
	unit_req_t   req;
	unit_rsp_t   rsp;

	vnm_unit u_unit (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// table address of the held node
	assign node_a = AW'(node_q);

	// table storage
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[node_a];
	end

	// magnitudes and helpers
	function automatic logic [31:0] mag(input comp_t v);
		logic signed [32:0] w;
		w = 33'(v);
		return w[32] ? 32'(-w) : 32'(w);
	endfunction

	comp_t cur;
	logic [31:0] cur_mag;
	logic signed [COMP_BITS+1:0] sum_w;
	comp_t sat_v;
	logic [31:0] q_rnd;
	always_comb begin
		cur     = c_q[k_q];
		cur_mag = mag(cur);
		sum_w   = (COMP_BITS + 2)'(u_q[k_q]) + (COMP_BITS + 2)'(e_q[k_q]);
		if (sum_w > (COMP_BITS + 2)'(COMP_MAX))
			sat_v = COMP_MAX;
		else if (sum_w < (COMP_BITS + 2)'(COMP_MIN))
			sat_v = COMP_MIN;
		else
			sat_v = COMP_BITS'(sum_w);
		q_rnd = rsp.res;
	end

	logic accept;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			init_q   <= '0;
			pres_q   <= PRESENCE_RESET;
			merge_q  <= MERGE_RESET;
			m_tvalid <= 1'b0;
			req.start <= 1'b0;
			we       <= 1'b0;
		end else begin
			req.start <= 1'b0;
			we        <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PRESENCE: pres_q  <= cfg_wdata;
					default:      merge_q <= cfg_wdata;
				endcase
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					we <= 1'b1;
					wa <= init_q[AW-1:0];
					wd <= '0;
					init_q <= init_q + 1'b1;
					if (init_q == (AW + 1)'(NODE_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) begin
					cmd_q  <= s_tuser;
					node_q <= s_tdata[9:0];
					e_q[0] <= s_tdata[10 +: COMP_BITS];
					e_q[1] <= s_tdata[10 + COMP_BITS +: COMP_BITS];
					e_q[2] <= s_tdata[10 + 2 * COMP_BITS +: COMP_BITS];
					inr_q  <= 32'(s_tdata[9:0]) < 32'(NODE_COUNT);
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_SQ;
				ST_SQ: begin
					c_q[0] <= rd_q[0 +: COMP_BITS];
					c_q[1] <= rd_q[COMP_BITS +: COMP_BITS];
					c_q[2] <= rd_q[2 * COMP_BITS +: COMP_BITS];
					u_q[0] <= '0; u_q[1] <= '0; u_q[2] <= '0;
					sq_q <= '0;
					k_q  <= '0;
					if (!inr_q || cmd_q == CMD_UNDEF) begin
						if (cmd_q == CMD_READ) begin
							zero_q  <= 1'b1;
							state_q <= ST_OUT;
						end else
							state_q <= ST_IDLE;
					end else if (cmd_q == CMD_CLEAR) begin
						we <= 1'b1; wa <= node_a; wd <= '0;
						state_q <= ST_IDLE;
					end else
						state_q <= ST_SQ2;
				end
				// squared length, one square a cycle
				ST_SQ2: begin
					sq_q <= sq_q + 64'(cur_mag) * 64'(cur_mag);
					k_q  <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cmd_q == CMD_ACCUM &&
					    !(sq_q > 64'(pres_q) * 64'(pres_q))) begin
						we <= 1'b1; wa <= node_a;
						wd <= {e_q[2], e_q[1], e_q[0]};
						state_q <= ST_IDLE;
					end else if (sq_q == '0) begin
						zero_q  <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						zero_q    <= 1'b0;
						req.start <= 1'b1;
						req.op    <= OP_SQRT;
						req.num   <= sq_q;
						state_q   <= ST_DIV;
						k_q       <= 2'd3;
					end
				end
				// square root then one division per component
				ST_DIV: if (rsp.done) begin
					if (k_q == 2'd3) len_q <= rsp.res;
					else u_q[k_q] <= cur[COMP_BITS-1] ? -COMP_BITS'(q_rnd) : COMP_BITS'(q_rnd);
					if (k_q == 2'd2) begin
						k_q <= '0;
						dot_q <= '0;
						state_q <= (cmd_q == CMD_READ) ? ST_OUT : ST_DOT;
					end else begin
						automatic logic [1:0] nk = (k_q == 2'd3) ? 2'd0 : k_q + 2'd1;
						automatic logic [31:0] ln = (k_q == 2'd3) ? rsp.res : len_q;
						automatic logic [31:0] am = mag(c_q[nk]);
						k_q <= nk;
						req.start <= 1'b1;
						req.op    <= OP_DIV;
						req.num   <= (64'(am) << FRAC_BITS) + 64'(ln >> 1);
						req.den   <= ln;
					end
				end
				// dot product, multiply registered then summed
				ST_DOT: begin
					prod_s1 <= 64'(u_q[k_q]) * 64'(e_q[k_q]);
					state_q <= ST_DOT2;
				end
				ST_DOT2: begin
					dot_q <= dot_q + prod_s1;
					if (k_q == 2'd2) state_q <= ST_WR;
					else begin
						k_q <= k_q + 2'd1;
						state_q <= ST_DOT;
					end
				end
				ST_WR: begin
					if (dot_q > (64'(merge_q) <<< FRAC_BITS)) begin
						c_q[k_q] <= sat_v;
						if (k_q == 2'd0) begin
							we <= 1'b1; wa <= node_a;
							wd <= {c_q[2], c_q[1], sat_v};
							state_q <= ST_IDLE;
						end else k_q <= k_q - 2'd1;
					end else begin
						we <= 1'b1; wa <= node_a;
						wd <= {u_q[2], u_q[1], u_q[0]};
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					m_tuser  <= zero_q;
					m_tdata  <= {{PW{1'b0}}, u_q[2], u_q[1], u_q[0], node_q};
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/vnm_unit.sv */
// Shared iterative unit: integer square root of a 64-bit value, or
// unsigned 64/32 division, one result bit per cycle.
module vnm_unit
	import vnm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	op_t         op_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] acc_q;
	logic [63:0] num_q;
	logic [31:0] den_q;

	// restoring square root: two radicand bits per step
	logic [65:0] sq_try;
	logic [65:0] sq_rem;
	// restoring division: one dividend bit per step
	logic [64:0] dv_rem;

	always_comb begin
		sq_rem = {rem_q[63:0], num_q[63:62]};
		sq_try = sq_rem - {acc_q[63:0], 2'b01};
		dv_rem = {rem_q[63:0], num_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				acc_q  <= '0;
				cnt_q  <= (req.op == OP_SQRT) ? 6'd31 : 6'd63;
			end else if (busy_q) begin
				unique case (op_q)
					OP_SQRT: begin
						num_q <= {num_q[61:0], 2'b00};
						if (!sq_try[65]) begin
							rem_q <= sq_try[63:0];
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= sq_rem[63:0];
							acc_q <= {acc_q[62:0], 1'b0};
						end
					end
					default: begin
						num_q <= {num_q[62:0], 1'b0};
						if (dv_rem >= {33'd0, den_q}) begin
							rem_q <= 64'(dv_rem - {33'd0, den_q});
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= dv_rem[63:0];
							acc_q <= {acc_q[62:0], 1'b0};
						end
					end
				endcase
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = {done_q, acc_q[31:0]};

endmodule

/* rtl/vnm_checker.sv */
// Port-level checks for the normal table.
module vnm_checker
	import vnm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tuser
);

	// a stalled result word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

	// a stalled result keeps its zero flag
	a_user: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tuser)) else $error("tuser changed");

	// one word at a time: no input taken right after one
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second word taken");

	// no input taken while a result waits
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with result pending");

endmodule

bind vertex_normal_merge vnm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser)
);

/* bench/vertex_normal_merge_tb.sv */
module vertex_normal_merge_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vnm_pkg::*;

	localparam int NODES = 1024;
	localparam int CB = 18;
	localparam int DW = ((10 + 3 * CB + 7) / 8) * 8;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef logic signed [CB-1:0] comp_t;

	typedef struct {
		logic [9:0] node;
		comp_t      ux, uy, uz;
		logic       zero;
	} normal_rd_t;

	// predictor of the normal table plus queue of pending read words
	class normal_board;
		longint tbl[NODES][3];
		longint presence;
		longint merge;
		normal_rd_t pending[$];
		int errors;

		function new();
			for (int i = 0; i < NODES; i++)
				for (int k = 0; k < 3; k++) tbl[i][k] = 0;
			presence = PRESENCE_RESET;
			merge = 64'(signed'(MERGE_RESET));
			errors = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [15:0] val);
			if (idx == REG_PRESENCE) presence = val;
			else merge = longint'(signed'(val));
		endfunction

		function longint root(longint n);
			longint r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint sqlen(longint c[3]);
			return c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		endfunction

		// unit vector, rounded half away from zero; returns 0 for zero vector
		function bit unitize(longint c[3], output longint u[3]);
			longint s, len, a, q;
			s = sqlen(c);
			u = '{0, 0, 0};
			if (s == 0) return 0;
			len = root(s);
			for (int i = 0; i < 3; i++) begin
				a = c[i] < 0 ? -c[i] : c[i];
				q = (a * 16384 + len / 2) / len;
				u[i] = c[i] < 0 ? -q : q;
			end
			return 1;
		endfunction

		function longint clip(longint v);
			longint hi;
			hi = (64'd1 << (CB - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void note_word(logic [1:0] cmd, logic [9:0] node, comp_t ex, comp_t ey,
				comp_t ez);
			longint e[3], u[3], ent[3], dot;
			normal_rd_t r;
			bit nz;
			e = '{ex, ey, ez};
			if (cmd == CMD_READ) begin
				ent = '{tbl[node][0], tbl[node][1], tbl[node][2]};
				nz = unitize(ent, u);
				r.node = node;
				r.ux = comp_t'(u[0]);
				r.uy = comp_t'(u[1]);
				r.uz = comp_t'(u[2]);
				r.zero = !nz;
				pending.insert(pending.size(), r);
			end else if (cmd == CMD_CLEAR) begin
				for (int i = 0; i < 3; i++) tbl[node][i] = 0;
			end else if (cmd == CMD_ACCUM) begin
				ent = '{tbl[node][0], tbl[node][1], tbl[node][2]};
				if (sqlen(ent) > presence * presence) begin
					void'(unitize(ent, u));
					dot = 0;
					for (int i = 0; i < 3; i++) begin
						tbl[node][i] = u[i];
						dot += u[i] * e[i];
					end
					if (dot > merge * 16384)
						for (int i = 0; i < 3; i++) tbl[node][i] = clip(u[i] + e[i]);
				end else begin
					for (int i = 0; i < 3; i++) tbl[node][i] = e[i];
				end
			end
		endfunction

		function void check_word(logic [DW-1:0] d, logic z);
			normal_rd_t x;
			if (pending.size() == 0) begin
				$error("read word with nothing pending");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (d[9:0] !== x.node) begin
				$error("out_node exp %0d got %0d", x.node, d[9:0]); errors++;
			end
			if (comp_t'(d[10 +: CB]) !== x.ux) begin
				$error("unit_x exp %0d got %0d", x.ux, comp_t'(d[10 +: CB])); errors++;
			end
			if (comp_t'(d[10 + CB +: CB]) !== x.uy) begin
				$error("unit_y exp %0d got %0d", x.uy, comp_t'(d[10 + CB +: CB])); errors++;
			end
			if (comp_t'(d[10 + 2 * CB +: CB]) !== x.uz) begin
				$error("unit_z exp %0d got %0d", x.uz, comp_t'(d[10 + 2 * CB +: CB]));
				errors++;
			end
			if (z !== x.zero) begin
				$error("zero_vector exp %0d got %0d", x.zero, z); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [DW-1:0] s_tdata, m_tdata;
	logic [1:0] s_tuser;
	logic m_tuser;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_wdata;

	normal_board board;
	int send_idle, recv_idle;
	bit recv_hold;
	longint cycles;

	vertex_normal_merge u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("vertex_normal_merge verification failed");
				$finish;
			end
		end
	end

	// receiver: random stall, with an optional long hold-off
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
	end

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		board.set_reg(idx, val);
	endtask

	// tvalid stays up into the next word; it drops on idle or at a phase end
	task automatic send_word(logic [1:0] cmd, logic [9:0] node, comp_t ex, comp_t ey,
			comp_t ez);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {{(DW - 10 - 3 * CB){1'b0}}, ez, ey, ex, node};
		do @(posedge clk); while (!s_tready);
		board.note_word(cmd, node, ex, ey, ez);
		@(negedge clk);
	endtask

	// wait for pending reads, then the slowest command's latency
	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic comp_t rnd_comp();
		case ($urandom_range(3))
			0: return comp_t'($urandom);
			1: return comp_t'($signed($urandom_range(32768)) - 16384);
			2: return $urandom_range(1) ? comp_t'(131071) : comp_t'(-131072);
			default: return comp_t'($signed($urandom_range(2000)) - 1000);
		endcase
	endfunction

	// mostly accumulate/read on few nodes so merges hit stored normals
	task automatic random_phase(int n);
		logic [9:0] node;
		int r;
		comp_t bx, by, bz;
		for (int i = 0; i < n; i++) begin
			node = $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(15));
			r = $urandom_range(99);
			if (r < 50) begin
				// near-parallel normals to cross the merge test
				if ($urandom_range(1)) begin
					bx = comp_t'(16384 + $signed($urandom_range(8000)) - 4000);
					by = comp_t'($signed($urandom_range(8000)) - 4000);
					bz = comp_t'($signed($urandom_range(8000)) - 4000);
					send_word(CMD_ACCUM, node, bx, by, bz);
				end else begin
					send_word(CMD_ACCUM, node, rnd_comp(), rnd_comp(), rnd_comp());
				end
			end else if (r < 88) begin
				send_word(CMD_READ, node, rnd_comp(), rnd_comp(), rnd_comp());
			end else if (r < 95) begin
				send_word(CMD_CLEAR, node, rnd_comp(), rnd_comp(), rnd_comp());
			end else begin
				send_word(CMD_UNDEF, node, rnd_comp(), rnd_comp(), rnd_comp());
			end
		end
		s_tvalid <= 0;
	endtask

	initial begin
		board = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		recv_hold = 0;
		send_idle = 0;
		recv_idle = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;

		// directed: extremes, every command, zero read, undefined command
		send_word(CMD_READ, 10'd0, 0, 0, 0);
		send_word(CMD_ACCUM, 10'd1023, 131071, -131072, 0);
		send_word(CMD_READ, 10'd1023, 0, 0, 0);
		send_word(CMD_ACCUM, 10'd1023, 131071, 131071, 131071);
		send_word(CMD_READ, 10'd1023, 0, 0, 0);
		send_word(CMD_ACCUM, 10'd5, 16384, 0, 0);
		send_word(CMD_ACCUM, 10'd5, 16000, 300, -200);
		send_word(CMD_ACCUM, 10'd5, -16384, 0, 0);
		send_word(CMD_READ, 10'd5, 0, 0, 0);
		send_word(CMD_ACCUM, 10'd6, 8192, 0, 0);
		send_word(CMD_ACCUM, 10'd6, 0, 16384, 0);
		send_word(CMD_READ, 10'd6, 0, 0, 0);
		send_word(CMD_ACCUM, 10'd7, -131072, -131072, -131072);
		send_word(CMD_ACCUM, 10'd7, -131072, -131072, -131072);
		send_word(CMD_READ, 10'd7, 0, 0, 0);
		send_word(CMD_UNDEF, 10'd7, 1, 1, 1);
		send_word(CMD_CLEAR, 10'd7, -1, -1, -1);
		send_word(CMD_READ, 10'd7, 0, 0, 0);
		send_word(CMD_CLEAR, 10'd1023, 0, 0, 0);
		send_word(CMD_READ, 10'd1023, 0, 0, 0);
		s_tvalid <= 0;
		drain();

		// sender idles rarely, receiver often
		send_idle = 9;
		recv_idle = 58;
		write_reg(REG_PRESENCE, 16'd0);
		write_reg(REG_MERGE, 16'h8000);
		random_phase(300);
		drain();

		// other way round, with a long receiver hold-off
		send_idle = 58;
		recv_idle = 9;
		write_reg(REG_PRESENCE, 16'hFFFF);
		write_reg(REG_MERGE, 16'h7FFF);
		fork
			begin
				recv_hold = 1;
				repeat (3000) @(negedge clk);
				recv_hold = 0;
			end
			random_phase(300);
		join
		drain();

		// no idling
		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_PRESENCE, 16'd8192);
		write_reg(REG_MERGE, 16'd11469);
		random_phase(450);
		drain();
		write_reg(REG_PRESENCE, 16'd20000);
		write_reg(REG_MERGE, 16'd0);
		random_phase(300);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("vertex_normal_merge verification clean");
		end else begin
			if (board.pending.size() != 0) $error("%0d reads never returned",
				board.pending.size());
			$display("vertex_normal_merge verification failed");
		end
		$finish;
	end
endmodule
